// File: src/crcfd_pkg.sv
// shared types, codes and crc update function for the crc16 frame deframer
`timescale 1ns / 1ps
package crcfd_pkg;

	localparam int unsigned POS_W  = 17;
	localparam int unsigned CFG_W  = 16;
	localparam int unsigned IDX_W  = 2;
	localparam int unsigned TDATA_W = 48;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_MSB  = 16'h8000;

	localparam logic [POS_W-1:0] POS_SYNC    = POS_W'(0);
	localparam logic [POS_W-1:0] POS_VERSION = POS_W'(1);
	localparam logic [POS_W-1:0] POS_CMD     = POS_W'(2);
	localparam logic [POS_W-1:0] POS_SEQ     = POS_W'(3);
	localparam logic [POS_W-1:0] POS_LEN_LO  = POS_W'(4);
	localparam logic [POS_W-1:0] POS_LEN_HI  = POS_W'(5);
	localparam logic [POS_W-1:0] HDR_BYTES   = POS_W'(6);

	typedef enum logic [IDX_W-1:0] {
		REG_SYNC    = 2'd0,
		REG_VERSION = 2'd1,
		REG_LIMIT   = 2'd2,
		REG_UNUSED  = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_SYNC     = 3'd1,
		ST_VERSION  = 3'd2,
		ST_TOO_LONG = 3'd3,
		ST_TRUNC    = 3'd4,
		ST_CRC      = 3'd5
	} status_t;

	typedef struct packed {
		logic [7:0]  sync_value;
		logic [7:0]  version_value;
		logic [15:0] payload_limit;
	} cfg_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  payload_byte;
		status_t     status;
		logic [7:0]  frame_cmd;
		logic [7:0]  frame_seq;
		logic [15:0] frame_length;
	} res_t;

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
			input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if ((c & CRC_MSB) != 16'h0000) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// File: src/crcfd_parse.sv
// input register and frame parser: header checks, crc update, result build
`timescale 1ns / 1ps
module crcfd_parse (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [7:0]     in_byte,
	input  logic           in_last,
	input  crcfd_pkg::cfg_t cfg,
	output logic           res_valid,
	input  logic           res_ready,
	output crcfd_pkg::res_t res
);
	import crcfd_pkg::*;

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             last_s1;
	logic             fire;

	logic [POS_W-1:0] pos_q;
	logic [15:0]      crc_q;
	logic [7:0]       cmd_q;
	logic [7:0]       seq_q;
	logic [15:0]      len_q;
	logic [7:0]       rx_lo_q;
	logic             decided_q;

	logic [POS_W-1:0] payload_end;
	logic [15:0]      crc_upd;
	logic [15:0]      crc_n;
	logic [7:0]       cmd_n;
	logic [7:0]       seq_n;
	logic [15:0]      len_n;
	logic [7:0]       rx_lo_n;
	logic             has_status;
	status_t          status_c;
	logic             emit;

	assign in_ready = !valid_s1 || res_ready;
	assign fire     = valid_s1 && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	assign payload_end = HDR_BYTES + {1'b0, len_q};
	assign crc_upd     = crc16_byte(crc_q, byte_s1);

	always_comb begin
		crc_n      = crc_q;
		cmd_n      = cmd_q;
		seq_n      = seq_q;
		len_n      = len_q;
		rx_lo_n    = rx_lo_q;
		has_status = 1'b0;
		status_c   = ST_OK;
		emit       = 1'b0;
		if (!decided_q) begin
			if (pos_q == POS_SYNC) begin
				if (byte_s1 != cfg.sync_value) begin
					has_status = 1'b1;
					status_c   = ST_SYNC;
				end else begin
					crc_n = crc_upd;
				end
			end else if (pos_q == POS_VERSION) begin
				if (byte_s1 != cfg.version_value) begin
					has_status = 1'b1;
					status_c   = ST_VERSION;
				end else begin
					crc_n = crc_upd;
				end
			end else if (pos_q == POS_CMD) begin
				cmd_n = byte_s1;
				crc_n = crc_upd;
			end else if (pos_q == POS_SEQ) begin
				seq_n = byte_s1;
				crc_n = crc_upd;
			end else if (pos_q == POS_LEN_LO) begin
				len_n = {8'h00, byte_s1};
				crc_n = crc_upd;
			end else if (pos_q == POS_LEN_HI) begin
				len_n = {byte_s1, len_q[7:0]};
				crc_n = crc_upd;
				if (len_n > cfg.payload_limit) begin
					has_status = 1'b1;
					status_c   = ST_TOO_LONG;
				end
			end else if (pos_q < payload_end) begin
				crc_n = crc_upd;
				emit  = 1'b1;
			end else if (pos_q == payload_end) begin
				rx_lo_n = byte_s1;
			end else begin
				has_status = 1'b1;
				status_c   = ({byte_s1, rx_lo_q} == crc_q) ? ST_OK : ST_CRC;
			end
			if (!has_status && last_s1) begin
				has_status = 1'b1;
				status_c   = ST_TRUNC;
			end
			if (has_status) begin
				emit = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			crc_q     <= CRC_INIT;
			cmd_q     <= '0;
			seq_q     <= '0;
			len_q     <= '0;
			rx_lo_q   <= '0;
			decided_q <= 1'b0;
		end else if (fire) begin
			if (last_s1) begin
				pos_q     <= '0;
				crc_q     <= CRC_INIT;
				cmd_q     <= '0;
				seq_q     <= '0;
				len_q     <= '0;
				rx_lo_q   <= '0;
				decided_q <= 1'b0;
			end else if (!decided_q) begin
				pos_q     <= pos_q + POS_W'(1);
				crc_q     <= crc_n;
				cmd_q     <= cmd_n;
				seq_q     <= seq_n;
				len_q     <= len_n;
				rx_lo_q   <= rx_lo_n;
				decided_q <= has_status;
			end
		end
	end

	assign res_valid        = fire && (has_status || emit);
	assign res.kind         = has_status;
	assign res.payload_byte = has_status ? 8'h00 : byte_s1;
	assign res.status       = has_status ? status_c : ST_OK;
	assign res.frame_cmd    = cmd_n;
	assign res.frame_seq    = seq_n;
	assign res.frame_length = len_n;

endmodule

// File: src/crcfd_skid.sv
// output register with skid stage for result beats
`timescale 1ns / 1ps
module crcfd_skid (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  crcfd_pkg::res_t in_res,
	output logic            out_valid,
	input  logic            out_ready,
	output crcfd_pkg::res_t out_res
);
	import crcfd_pkg::*;

	logic out_valid_q;
	logic skid_valid_q;
	res_t main_q;
	res_t skid_q;
	logic load_main;

	assign in_ready  = !skid_valid_q;
	assign load_main = out_ready || !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (load_main) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_valid;
			end
		end else if (in_valid && !skid_valid_q) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_main) begin
			main_q <= skid_valid_q ? skid_q : in_res;
		end else if (in_valid && !skid_valid_q) begin
			skid_q <= in_res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = main_q;

endmodule

// File: src/crc16_frame_deframer.sv
// top level of the crc16 framed packet deframer
// Takes one buffer byte per beat on the slave side, one beat every cycle unless stalled.
// Each byte passes through an input register and the parser, which checks the header,
// updates the CRC-16/CCITT-FALSE a whole byte per cycle when not stalled and builds at
// most one result beat; results leave through an output register with a skid stage, so
// the input stays open while a result waits; input and result beats are registered.
// Payload bytes go out with tlast low; the single status beat of a frame has tlast high.
// Bytes after the status are dropped up to the end of the buffer (s_axis_tlast).
`timescale 1ns / 1ps
module crc16_frame_deframer #(
	parameter logic [7:0]  SYNC_RESET    = 8'hA5,
	parameter logic [7:0]  VERSION_RESET = 8'h01,
	parameter logic [15:0] LIMIT_RESET   = 16'd256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [7:0]                      s_axis_tdata,   // data_byte
	input  logic                            s_axis_tlast,   // end_of_buffer
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// payload_byte[7:0], status[10:8], frame_cmd[18:11], frame_seq[26:19],
	// frame_length[42:27], zero[47:43]
	output logic [crcfd_pkg::TDATA_W-1:0]   m_axis_tdata,
	output logic                            m_axis_tlast,   // kind
	input  logic                            cfg_we,
	input  logic [crcfd_pkg::IDX_W-1:0]     cfg_index,
	input  logic [crcfd_pkg::CFG_W-1:0]     cfg_data
);
	import crcfd_pkg::*;

	cfg_t cfg_q;
	logic res_valid;
	logic res_ready;
	res_t res;
	res_t out_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_value    <= SYNC_RESET;
			cfg_q.version_value <= VERSION_RESET;
			cfg_q.payload_limit <= LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SYNC:    cfg_q.sync_value    <= cfg_data[7:0];
				REG_VERSION: cfg_q.version_value <= cfg_data[7:0];
				REG_LIMIT:   cfg_q.payload_limit <= cfg_data;
				default:     ;
			endcase
		end
	end

	crcfd_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_byte   (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	crcfd_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (res_valid),
		.in_ready  (res_ready),
		.in_res    (res),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	assign m_axis_tlast = out_res.kind;
	assign m_axis_tdata = {5'b00000, out_res.frame_length, out_res.frame_seq,
		out_res.frame_cmd, out_res.status, out_res.payload_byte};

	a_status_no_payload: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[7:0] == 8'h00)
		else $error("status beat carries payload bits");

	a_payload_ok_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[10:8] == ST_OK)
		else $error("payload beat carries a status code");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[10:8] <= ST_CRC && m_axis_tdata[47:43] == 5'b00000)
		else $error("result beat out of range");

	a_sync_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && cfg_index == REG_SYNC |=> cfg_q.sync_value == $past(cfg_data[7:0]))
		else $error("sync register write lost");

endmodule
